// ===== design/swrf_pkg.sv =====
// Shared types and constants for the sliding window rank filter.
// No dependencies; imported by every module of the block.
package swrf_pkg;

    localparam int SAMPLE_W = 8;
    localparam int HW_W     = 4;
    localparam int RANK_W   = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_WIDTH = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK_INDEX = 1'd1;

    // Reset values of the configuration registers.
    localparam logic [HW_W-1:0]   HALF_WIDTH_RST = 4'd2;
    localparam logic [RANK_W-1:0] RANK_INDEX_RST = 5'd2;

    typedef logic [SAMPLE_W-1:0] t_sample;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFTZ,
        S_LOAD,
        S_RANK,
        S_EMIT
    } t_state;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic shift;
        logic clear;
        logic load;
        logic rotate;
    } t_cell_ctl;

endpackage

// ===== design/swrf_cell.sv =====
// One cell of the rank filter chain: a window tap plus a rank counter.
// Depends on swrf_pkg for the sample type and the control struct.
module swrf_cell import swrf_pkg::*; #(
    parameter int IDX_W = 5,
    parameter int IDX   = 0
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cell_ctl        i_ctl,
    input  t_sample          i_shift_data,
    input  t_sample          i_circ,
    input  logic [IDX_W-1:0] i_cidx,
    output t_sample          o_win,
    output t_sample          o_key,
    output t_sample          o_circ,
    output logic [IDX_W-1:0] o_cidx,
    output logic [IDX_W-1:0] o_cnt
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    t_sample          r_win;
    t_sample          r_key;
    t_sample          r_circ;
    logic [IDX_W-1:0] r_cidx;
    logic [IDX_W-1:0] r_cnt;
    logic             beats;

    // The passing value ranks below this key if it is smaller, or equal
    // and from a newer position in the window order.
    assign beats = (r_circ < r_key) || ((r_circ == r_key) && (r_cidx < MY_IDX));

    // Window tap: shifts toward older positions, cleared at reset and scan end.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_win <= '0;
        end else if (i_ctl.shift) begin
            r_win <= i_shift_data;
        end
    end

    // Rank counting: the key stays, the circulating value moves along the ring.
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_key  <= r_win;
            r_circ <= r_win;
            r_cidx <= MY_IDX;
            r_cnt  <= '0;
        end else if (i_ctl.rotate) begin
            r_circ <= i_circ;
            r_cidx <= i_cidx;
            r_cnt  <= r_cnt + IDX_W'(beats);
        end
    end

    assign o_win  = r_win;
    assign o_key  = r_key;
    assign o_circ = r_circ;
    assign o_cidx = r_cidx;
    assign o_cnt  = r_cnt;

endmodule

// ===== design/sliding_window_rank_filter.sv =====
// Sliding window rank filter: each result is the chosen ascending rank of the
// 2W+1 samples centred on one bin (W = half_width), with positions outside
// the scan read as zero, so results lag the input by W items. An item that
// gives no result does not stall the input. An item that gives a result
// keeps the input stalled while the cells load the window, every window value
// travels once around the ring of cells so each cell counts how many values
// rank below its own, and the result is handed to the output register once
// that register is free. The final item of a scan flushes up to W+1 results;
// a zero is shifted into the window before each of them but the final item's
// own result, except that when only P < W bins were pending as the final
// item arrived, W-P zeros are shifted in before the first of them.
// The output register lets a new item enter while a result waits to be taken.
module sliding_window_rank_filter import swrf_pkg::*; #(
    parameter int MAX_HALF_WIDTH = 15
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input items.
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [SAMPLE_W-1:0]   i_sample,
    input  logic                  i_last_in,
    // Result items.
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [SAMPLE_W-1:0]   o_filtered,
    output logic                  o_last_out,
    // Configuration writes.
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH = 2 * MAX_HALF_WIDTH + 1;
    localparam int IW    = $clog2(DEPTH);
    localparam int WW    = $clog2(MAX_HALF_WIDTH + 1);
    localparam logic [5:0] MAX6 = 6'(MAX_HALF_WIDTH);

    // Configuration registers.
    logic [HW_W-1:0]   r_half_width;
    logic [RANK_W-1:0] r_rank_index;

    // Sequencer.
    t_state          r_state;
    t_state          n_state;
    logic [WW-1:0]   r_pending;
    logic [WW-1:0]   r_zshift;
    logic [WW-1:0]   r_fl_outs;
    logic            r_cur_last;
    logic            r_scan_end;
    logic [IW-1:0]   r_rot_cnt;

    // Output register.
    logic            r_out_valid;
    t_sample         r_out_data;
    logic            r_out_last;

    // Derived window figures.
    logic [5:0]      hw6;
    logic [5:0]      rank6;
    logic [5:0]      tw6;
    logic [WW-1:0]   w_eff;
    logic [IW-1:0]   two_w;
    logic [IW-1:0]   rank_sel;
    logic [WW-1:0]   p_eff;
    logic [WW-1:0]   c_next;
    logic            p_full;
    logic            w_zero;
    logic            out_first;
    logic            flush_start;

    logic            in_accept;
    logic            emit_done;
    t_cell_ctl       ctl;
    t_sample         shift_data;
    t_sample         sel_value;

    // Cell chain signals.
    t_sample         win  [DEPTH];
    t_sample         key  [DEPTH];
    t_sample         circ [DEPTH];
    logic [IW-1:0]   cidx [DEPTH];
    logic [IW-1:0]   cnt  [DEPTH];
    t_sample         circ_in [DEPTH];
    logic [IW-1:0]   cidx_in [DEPTH];
    t_sample         shin [DEPTH];
    logic [DEPTH-1:0] match;

    // Configuration is always accepted.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_width <= HALF_WIDTH_RST;
            r_rank_index <= RANK_INDEX_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_HALF_WIDTH: r_half_width <= i_cfg_data[HW_W-1:0];
                CFG_RANK_INDEX: r_rank_index <= i_cfg_data[RANK_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective half width, rank and pending count.
    assign hw6      = {2'b00, r_half_width};
    assign w_eff    = WW'((hw6 > MAX6) ? MAX6 : hw6);
    assign two_w    = IW'({w_eff, 1'b0});
    assign tw6      = 6'(two_w);
    assign rank6    = {1'b0, r_rank_index};
    assign rank_sel = IW'((rank6 > tw6) ? tw6 : rank6);
    assign p_eff    = (r_pending > w_eff) ? w_eff : r_pending;
    assign p_full   = (p_eff == w_eff);
    assign c_next   = p_full ? w_eff : p_eff + WW'(1);
    assign w_zero   = (w_eff == '0);

    // A result is due right away once the window is full; a final item with
    // zero half width gives its own final result instead.
    assign out_first   = p_full || (i_last_in && w_zero);
    assign flush_start = i_last_in && !w_zero;

    assign in_accept = i_valid && !o_stall;
    assign emit_done = (r_state == S_EMIT) && (!r_out_valid || !i_stall);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    if (out_first) begin
                        n_state = S_LOAD;
                    end else if (flush_start) begin
                        n_state = S_SHIFTZ;
                    end
                end
            end
            S_SHIFTZ: begin
                if (r_zshift == WW'(1)) begin
                    n_state = S_LOAD;
                end
            end
            S_LOAD: n_state = S_RANK;
            S_RANK: begin
                if (r_rot_cnt == two_w) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_done) begin
                    n_state = (r_fl_outs != '0) ? S_SHIFTZ : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs to the input handshake and the cells.
    always_comb begin
        o_stall    = 1'b1;
        ctl        = '0;
        shift_data = '0;
        unique case (r_state)
            S_IDLE: begin
                o_stall    = 1'b0;
                ctl.shift  = in_accept;
                shift_data = i_sample;
            end
            S_SHIFTZ: ctl.shift  = 1'b1;
            S_LOAD:   ctl.load   = 1'b1;
            S_RANK:   ctl.rotate = 1'b1;
            S_EMIT:   ctl.clear  = emit_done && r_scan_end && (r_fl_outs == '0);
            default: ;
        endcase
    end

    // Sequencer registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pending  <= '0;
            r_zshift   <= WW'(1);
            r_fl_outs  <= '0;
            r_cur_last <= 1'b0;
            r_scan_end <= 1'b0;
            r_rot_cnt  <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_pending  <= i_last_in ? '0 : c_next;
                        r_scan_end <= i_last_in;
                        r_cur_last <= i_last_in && w_zero;
                        if (flush_start) begin
                            r_fl_outs <= c_next;
                            r_zshift  <= p_full ? WW'(1) : (w_eff - p_eff);
                        end else begin
                            r_fl_outs <= '0;
                            r_zshift  <= WW'(1);
                        end
                    end
                end
                S_SHIFTZ: begin
                    if (r_zshift == WW'(1)) begin
                        r_fl_outs  <= r_fl_outs - WW'(1);
                        r_cur_last <= (r_fl_outs == WW'(1));
                    end else begin
                        r_zshift <= r_zshift - WW'(1);
                    end
                end
                S_LOAD: r_rot_cnt <= '0;
                S_RANK: r_rot_cnt <= r_rot_cnt + IW'(1);
                default: ;
            endcase
        end
    end

    // Chain of cells: window shift to older taps, rank ring closed at tap 2W.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign shin[g] = shift_data;
        end else begin : g_body
            assign shin[g] = win[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign circ_in[g] = circ[0];
            assign cidx_in[g] = cidx[0];
        end else begin : g_ring
            assign circ_in[g] = (IW'(g) == two_w) ? circ[0] : circ[g+1];
            assign cidx_in[g] = (IW'(g) == two_w) ? cidx[0] : cidx[g+1];
        end

        swrf_cell #(
            .IDX_W (IW),
            .IDX   (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (ctl),
            .i_shift_data (shin[g]),
            .i_circ       (circ_in[g]),
            .i_cidx       (cidx_in[g]),
            .o_win        (win[g]),
            .o_key        (key[g]),
            .o_circ       (circ[g]),
            .o_cidx       (cidx[g]),
            .o_cnt        (cnt[g])
        );

        assign match[g] = (IW'(g) <= two_w) && (cnt[g] == rank_sel);
    end

    // Exactly one cell of the window holds the selected rank.
    always_comb begin
        sel_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_value = sel_value | (match[i] ? key[i] : '0);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit_done) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_done) begin
            r_out_data <= sel_value;
            r_out_last <= r_cur_last;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_filtered = r_out_data;
    assign o_last_out = r_out_last;

    // The rank pass never runs past the ring length.
    a_rot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RANK) |-> (r_rot_cnt <= two_w))
        else $error("rank counter ran past the window");

    // Counts form a permutation, so one cell matches the rank when a result is handed over.
    a_one_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> $onehot(match))
        else $error("rank selection is not unique");

    // A zero shift phase always has work left.
    a_zshift_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFTZ) |-> (r_zshift != '0))
        else $error("zero shift counter empty while shifting");

    // The final result of a scan clears the window and is marked last.
    a_last_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.clear |=> (o_valid && o_last_out && (r_state == S_IDLE)))
        else $error("window cleared without a final result");

endmodule

// ===== test/sliding_window_rank_filter_tb.sv =====
// Self-checking testbench for the sliding window rank filter.
// Needs swrf_pkg and sliding_window_rank_filter; it keeps its own rank
// predictor in a small scoreboard class and drives random idle and stall.
`timescale 1ns / 1ps

module sliding_window_rank_filter_tb;
    import swrf_pkg::*;

    localparam int STORE_DEPTH   = 31;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 320;

    typedef struct packed {
        t_sample filtered;
        logic    last_out;
    } t_rank_result;

    // Predicts the rank filter outputs and checks what the block returns.
    class rank_scoreboard;
        t_sample      window[STORE_DEPTH];
        int unsigned  pending;
        logic [HW_W-1:0]   half_width;
        logic [RANK_W-1:0] rank_sel;
        t_rank_result expected_ranks[$];
        int unsigned  errors;

        function new();
            foreach (window[i]) window[i] = '0;
            pending    = 0;
            half_width = HALF_WIDTH_RST;
            rank_sel   = RANK_INDEX_RST;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_HALF_WIDTH: half_width = data[HW_W-1:0];
                CFG_RANK_INDEX: rank_sel = data[RANK_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned outstanding();
            return expected_ranks.size();
        endfunction

        function void push_sample(t_sample v);
            for (int i = STORE_DEPTH - 1; i > 0; i--) window[i] = window[i-1];
            window[0] = v;
        endfunction

        // The selected rank is the value whose span of equal values covers it.
        function t_sample window_rank(int unsigned w);
            int unsigned r;
            int unsigned below;
            int unsigned not_above;
            r = rank_sel;
            if (r > 2 * w) r = 2 * w;
            for (int i = 0; i <= 2 * w; i++) begin
                below = 0;
                not_above = 0;
                for (int j = 0; j <= 2 * w; j++) begin
                    if (window[j] < window[i]) below++;
                    if (window[j] <= window[i]) not_above++;
                end
                if (r >= below && r < not_above) return window[i];
            end
            return '0;
        endfunction

        function void expect_rank(int unsigned w, logic last);
            t_rank_result res;
            res.filtered = window_rank(w);
            res.last_out = last;
            expected_ranks.insert(expected_ranks.size(), res);
        endfunction

        // Works out every result that one accepted input item causes.
        function void note_sample(t_sample sample, logic last);
            int unsigned w;
            int unsigned p;
            int unsigned carried;
            int unsigned oldest;
            w = half_width;
            p = (pending > w) ? w : pending;
            push_sample(sample);
            if (p == w) begin
                carried = w;
                if (!(last && w == 0)) expect_rank(w, 1'b0);
            end else begin
                carried = p + 1;
            end
            if (!last) begin
                pending = carried;
                return;
            end
            if (w == 0) begin
                expect_rank(0, 1'b1);
            end else begin
                // Shift zeros until the oldest bin not yet output sits at the centre.
                oldest = carried - 1;
                while (oldest < w) begin
                    push_sample('0);
                    oldest++;
                end
                for (int k = 0; k < carried; k++) begin
                    if (k > 0) push_sample('0);
                    expect_rank(w, (k + 1 == carried));
                end
            end
            foreach (window[i]) window[i] = '0;
            pending = 0;
        endfunction

        task report(string msg);
            errors++;
            $display("ERROR at %0t ns: %s", $time, msg);
        endtask

        task check_output(t_sample filtered, logic last_out);
            t_rank_result exp_res;
            if (expected_ranks.size() == 0) begin
                report($sformatf("result %0d/%0b with nothing expected", filtered, last_out));
                return;
            end
            exp_res = expected_ranks.pop_front();
            if (filtered !== exp_res.filtered)
                report($sformatf("filtered %0d, expected %0d", filtered, exp_res.filtered));
            if (last_out !== exp_res.last_out)
                report($sformatf("last_out %0b, expected %0b", last_out, exp_res.last_out));
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [SAMPLE_W-1:0]   i_sample;
    logic                  i_last_in;
    logic                  o_valid;
    logic                  i_stall;
    logic [SAMPLE_W-1:0]   o_filtered;
    logic                  o_last_out;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rank_scoreboard sb = new();
    int unsigned items_sent;
    int unsigned results_seen;

    sliding_window_rank_filter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_sample    (i_sample),
        .i_last_in   (i_last_in),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_filtered  (o_filtered),
        .o_last_out  (o_last_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog for a hung block.
    initial begin
        #(64'd8_000_000);
        $display("FAIL");
        $finish;
    end

    // Mostly short gaps, a few long ones.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_sample pick_sample();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        return t_sample'($urandom_range(0, 255));
    endfunction

    // Mostly narrow windows; bit 4 of the write data is don't-care for half width.
    function automatic logic [CFG_DATA_W-1:0] pick_half_width();
        int unsigned r;
        logic [HW_W-1:0] w;
        r = $urandom_range(0, 99);
        if (r < 70) w = HW_W'($urandom_range(0, 4));
        else if (r < 80) w = 4'd0;
        else if (r < 90) w = 4'd15;
        else w = HW_W'($urandom_range(5, 15));
        return {1'($urandom_range(0, 1)), w};
    endfunction

    // Offers one item after an optional gap and waits until it is taken.
    task automatic send_item(t_sample sample, logic last, int unsigned gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_sample  <= sample;
        i_last_in <= last;
        do @(posedge i_clk); while (o_stall);
        sb.note_sample(sample, last);
        items_sent++;
    endtask

    // Writes one register; the caller lowers the valid after its last write.
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_config(logic [CFG_DATA_W-1:0] hw, logic [CFG_DATA_W-1:0] rank);
        cfg_write(CFG_HALF_WIDTH, hw);
        cfg_write(CFG_RANK_INDEX, rank);
        i_cfg_valid <= 1'b0;
    endtask

    // Stops sending, waits for every expected result, then lets the block go quiet.
    task automatic settle();
        int unsigned guard;
        i_valid <= 1'b0;
        guard = 0;
        while (sb.outstanding() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result side: checks accepted results and drives random stall.
    int unsigned hold_left;
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned hold_mark;
    int unsigned stall_roll;
    logic        stall_next;

    initial begin
        i_stall    = 1'b0;
        hold_left  = 0;
        stall_left = 0;
        calm_left  = 0;
        hold_mark  = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                sb.check_output(o_filtered, o_last_out);
                results_seen++;
            end
            // Two long hold-offs so the block fills and stalls its input.
            if ((results_seen == 50 || results_seen == 250) && hold_mark != results_seen) begin
                hold_mark = results_seen;
                hold_left = 200;
            end
            if (hold_left > 0) begin
                hold_left--;
                stall_next = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                stall_next = 1'b1;
            end else if (calm_left > 0) begin
                calm_left--;
                stall_next = 1'b0;
            end else begin
                stall_roll = $urandom_range(0, 99);
                if (stall_roll < 12) stall_left = $urandom_range(1, 3);
                else if (stall_roll < 14) stall_left = $urandom_range(15, 60);
                else if (stall_roll < 18) calm_left = $urandom_range(20, 80);
                stall_next = 1'b0;
            end
            i_stall <= stall_next;
        end
    end

    // Input side: directed scans, then random scans and settings.
    initial begin
        int unsigned scan_len;
        int unsigned split_at;
        logic        reshape;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_sample     = '0;
        i_last_in    = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_HALF_WIDTH;
        i_cfg_data   = '0;
        items_sent   = 0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset settings, a short scan with both sample extremes.
        send_item(8'hFF, 1'b0, 0);
        send_item(8'h00, 1'b0, 0);
        send_item(8'h80, 1'b1, 0);

        // Zero half width: each sample comes straight back.
        settle();
        set_config(5'd0, 5'd0);
        send_item(8'h00, 1'b0, 0);
        send_item(8'hFF, 1'b1, pick_gap());

        // Widest window, maximum rank, flushed after four bins.
        settle();
        set_config(5'd15, 5'd30);
        send_item(8'hFF, 1'b0, 0);
        send_item(8'h00, 1'b0, 0);
        send_item(8'h01, 1'b0, 0);
        send_item(8'hFE, 1'b1, 0);

        // Rank above twice the half width picks the window maximum.
        settle();
        set_config(5'd1, 5'd31);
        send_item(8'd10, 1'b0, 0);
        send_item(8'd200, 1'b0, 0);
        send_item(8'd30, 1'b0, 0);
        send_item(8'd40, 1'b0, 0);
        send_item(8'd50, 1'b1, 0);

        // Half width narrowed and then widened in the middle of a scan.
        settle();
        set_config(5'b10011, 5'd3);
        send_item(8'd1, 1'b0, 0);
        send_item(8'd2, 1'b0, 0);
        send_item(8'd3, 1'b0, 0);
        send_item(8'd4, 1'b0, 0);
        send_item(8'd5, 1'b0, 0);
        settle();
        cfg_write(CFG_HALF_WIDTH, 5'd1);
        i_cfg_valid <= 1'b0;
        send_item(8'd6, 1'b0, 0);
        send_item(8'd7, 1'b1, 0);
        send_item(8'd9, 1'b0, 0);
        send_item(8'd8, 1'b0, 0);
        settle();
        cfg_write(CFG_HALF_WIDTH, 5'd4);
        i_cfg_valid <= 1'b0;
        send_item(8'd7, 1'b1, 0);

        // Random scans; settings change between scans and now and then mid-scan.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 30) begin
                settle();
                set_config(pick_half_width(), CFG_DATA_W'($urandom_range(0, 31)));
            end else if ($urandom_range(0, 99) < 8) begin
                settle();
            end
            scan_len = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 12)
                                                    : $urandom_range(13, 40);
            reshape  = ($urandom_range(0, 99) < 10);
            split_at = scan_len / 2;
            for (int k = 0; k < scan_len; k++) begin
                if (reshape && k == split_at && k > 0) begin
                    settle();
                    cfg_write(CFG_HALF_WIDTH, pick_half_width());
                    i_cfg_valid <= 1'b0;
                end
                send_item(pick_sample(), (k == scan_len - 1), pick_gap());
            end
        end

        settle();
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
